// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the infrared frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/irpw_pkg.sv =====
// Shared types, constants and reset values of the infrared frame decoder.
package irpw_pkg;

   localparam int DURATION_BITS = 8;
   localparam int CFG_BITS      = 8;
   localparam int CMP_BITS      = (DURATION_BITS > CFG_BITS) ? DURATION_BITS : CFG_BITS;
   localparam int FRAME_BITS    = 32;
   localparam int BITS_W        = $clog2(FRAME_BITS + 1);
   localparam int BYTE_BITS     = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W   = 3;

   localparam logic [CFG_BITS-1:0]  RESET_ZERO_MIN    = 8'd10;
   localparam logic [CFG_BITS-1:0]  RESET_ONE_MIN     = 8'd50;
   localparam logic [CFG_BITS-1:0]  RESET_REPEAT_MIN  = 8'd100;
   localparam logic [CFG_BITS-1:0]  RESET_LEAD_MIN    = 8'd200;
   localparam logic [CFG_BITS-1:0]  RESET_TIMEOUT     = 8'd250;
   localparam logic [BYTE_BITS-1:0] RESET_EXPECTED    = 8'd0;
   localparam logic [BYTE_BITS-1:0] REPEAT_SATURATE   = 8'hff;

   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_REPEAT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ZERO_MIN    = 3'd0,
      CSR_ONE_MIN     = 3'd1,
      CSR_REPEAT_MIN  = 3'd2,
      CSR_LEAD_MIN    = 3'd3,
      CSR_TIMEOUT     = 3'd4,
      CSR_ADDR_CHECK  = 3'd5,
      CSR_EXPECTED    = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      CLS_NOISE   = 3'd0,
      CLS_ZERO    = 3'd1,
      CLS_ONE     = 3'd2,
      CLS_REPEAT  = 3'd3,
      CLS_LEAD    = 3'd4,
      CLS_TIMEOUT = 3'd5
   } cls_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]  zero_min;
      logic [CFG_BITS-1:0]  one_min;
      logic [CFG_BITS-1:0]  repeat_min;
      logic [CFG_BITS-1:0]  lead_min;
      logic [CFG_BITS-1:0]  timeout;
      logic                 addr_check;
      logic [BYTE_BITS-1:0] expected_addr;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      cls_type cls;
   } q_head_type;

endpackage

// ===== src/irpw_front.sv =====
// Front end: sorts each incoming duration into a pulse class and queues it.
module irpw_front (
   input  logic                              req_valid,
   input  logic [irpw_pkg::DURATION_BITS-1:0] req_high_ticks,
   input  irpw_pkg::cfg_type                 cfg,
   input  logic                              q_full,
   output logic                              req_stall,
   output logic                              push,
   output irpw_pkg::cls_type                 push_cls
);
   import irpw_pkg::*;

   logic [CMP_BITS-1:0] dur;
   cls_type             cls;

   assign dur = CMP_BITS'(req_high_ticks);

   // First threshold that passes decides, longest class first.
   always_comb begin
      if (dur >= CMP_BITS'(cfg.timeout)) begin
         cls = CLS_TIMEOUT;
      end else if (dur >= CMP_BITS'(cfg.lead_min)) begin
         cls = CLS_LEAD;
      end else if (dur >= CMP_BITS'(cfg.repeat_min)) begin
         cls = CLS_REPEAT;
      end else if (dur >= CMP_BITS'(cfg.one_min)) begin
         cls = CLS_ONE;
      end else if (dur >= CMP_BITS'(cfg.zero_min)) begin
         cls = CLS_ZERO;
      end else begin
         cls = CLS_NOISE;
      end
   end

   assign req_stall = q_full;
   // Noise never changes state, so it is dropped here.
   assign push      = req_valid && !q_full && (cls != CLS_NOISE);
   assign push_cls  = cls;

endmodule

// ===== src/irpw_queue.sv =====
// Short queue of classified pulses between the front end and the frame engine.
module irpw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  irpw_pkg::cls_type     push_cls,
   input  logic                  pop,
   output irpw_pkg::q_head_type  head,
   output logic                  full
);
   import irpw_pkg::*;

   cls_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cls;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cls   = mem[rd_ptr_ff];
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

// ===== src/irpw_frame.sv =====
// Back end: assembles frames from queued pulses and holds the result word.
module irpw_frame (
   input  logic                                clock,
   input  logic                                reset,
   input  irpw_pkg::cfg_type                   cfg,
   input  irpw_pkg::q_head_type                head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [irpw_pkg::FRAME_BITS-1:0]     rsp_frame_word,
   output logic [irpw_pkg::BYTE_BITS-1:0]      rsp_address_byte,
   output logic [irpw_pkg::BYTE_BITS-1:0]      rsp_key_code,
   output logic                                rsp_frame_ok,
   output logic [irpw_pkg::BYTE_BITS-1:0]      rsp_repeat_count
);
   import irpw_pkg::*;

   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [BITS_W-1:0]     bits_ff, bits_in;
   logic                  in_frame_ff, in_frame_in;
   logic [BYTE_BITS-1:0]  repeats_ff, repeats_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  kind_ff, kind_in;
   logic [FRAME_BITS-1:0] word_ff, word_in;
   logic [BYTE_BITS-1:0]  addr_ff, addr_in;
   logic [BYTE_BITS-1:0]  key_ff, key_in;
   logic                  ok_ff, ok_in;
   logic [BYTE_BITS-1:0]  count_ff, count_in;

   logic                  out_free;
   logic                  load;
   logic [FRAME_BITS-1:0] shift_next;
   logic [BYTE_BITS-1:0]  b0, b1, b2, b3;
   logic                  frame_good;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && out_free;

   assign shift_next = {shift_ff[FRAME_BITS-2:0], (head.cls == CLS_ONE)};
   assign b0 = shift_next[31:24];
   assign b1 = shift_next[23:16];
   assign b2 = shift_next[15:8];
   assign b3 = shift_next[7:0];
   assign frame_good = (b0 == ~b1) && (b2 == ~b3) &&
                       (!cfg.addr_check || (b0 == cfg.expected_addr));

   always_comb begin
      shift_in    = shift_ff;
      bits_in     = bits_ff;
      in_frame_in = in_frame_ff;
      repeats_in  = repeats_ff;
      load        = 1'b0;
      kind_in     = kind_ff;
      word_in     = word_ff;
      addr_in     = addr_ff;
      key_in      = key_ff;
      ok_in       = ok_ff;
      count_in    = count_ff;
      if (pop) begin
         case (head.cls)
            CLS_TIMEOUT: begin
               in_frame_in = 1'b0;
               bits_in     = '0;
            end
            CLS_LEAD: begin
               shift_in    = '0;
               bits_in     = '0;
               repeats_in  = '0;
               in_frame_in = 1'b1;
            end
            CLS_REPEAT: begin
               if (repeats_ff != REPEAT_SATURATE) begin
                  repeats_in = repeats_ff + 1'b1;
               end
               load     = 1'b1;
               kind_in  = KIND_REPEAT;
               word_in  = '0;
               addr_in  = '0;
               key_in   = '0;
               ok_in    = 1'b0;
               count_in = repeats_in;
            end
            CLS_ZERO, CLS_ONE: begin
               if (in_frame_ff) begin
                  shift_in = shift_next;
                  if (bits_ff == BITS_W'(FRAME_BITS - 1)) begin
                     // Last bit of the frame: report it and drop back to idle.
                     bits_in     = '0;
                     in_frame_in = 1'b0;
                     load        = 1'b1;
                     kind_in     = KIND_FRAME;
                     word_in     = shift_next;
                     addr_in     = b0;
                     key_in      = frame_good ? b2 : '0;
                     ok_in       = frame_good;
                     count_in    = repeats_ff;
                  end else begin
                     bits_in = bits_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_ff      <= '0;
         in_frame_ff  <= 1'b0;
         repeats_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         bits_ff      <= bits_in;
         in_frame_ff  <= in_frame_in;
         repeats_ff   <= repeats_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         word_ff  <= word_in;
         addr_ff  <= addr_in;
         key_ff   <= key_in;
         ok_ff    <= ok_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_frame_word   = word_ff;
   assign rsp_address_byte = addr_ff;
   assign rsp_key_code     = key_ff;
   assign rsp_frame_ok     = ok_ff;
   assign rsp_repeat_count = count_ff;

endmodule

// ===== src/ir_pulse_width_frame_decoder.sv =====
// Top level of the pulse-width infrared remote frame decoder.
//
// This block decodes remote-control frames of the common pulse-distance
// format from a stream of measured high-level durations, one duration per
// input word. Each duration is compared against five programmable thresholds
// and sorted into noise, zero bit, one bit, repeat code, lead pulse or
// timeout; noise is dropped. A lead pulse opens a frame, thirty-two data bits
// follow with the first bit landing in the most significant position, and the
// thirty-second bit produces one frame word carrying the raw frame, the
// address byte, the key byte and a validity flag from the two byte-complement
// checks plus the optional address match. A repeat code produces a repeat
// word with a saturating count of repeats since the last lead pulse. The
// block takes one duration word per clock cycle while the queue has room:
// the classifier feeds a two-entry queue and the frame engine drains one
// entry per cycle into a single output register while it is free, and
// req_stall rises only when the queue is full because the output side has
// been stalling. The thresholds and address settings are written through
// the csr port, which is always ready, and must only be changed while no
// words are in flight.
`include "assert_macros.svh"

module ir_pulse_width_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [irpw_pkg::DURATION_BITS-1:0]   req_high_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_kind,
   output logic [irpw_pkg::FRAME_BITS-1:0]      rsp_frame_word,
   output logic [irpw_pkg::BYTE_BITS-1:0]       rsp_address_byte,
   output logic [irpw_pkg::BYTE_BITS-1:0]       rsp_key_code,
   output logic                                 rsp_frame_ok,
   output logic [irpw_pkg::BYTE_BITS-1:0]       rsp_repeat_count,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [irpw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [irpw_pkg::CFG_BITS-1:0]        csr_data
);
   import irpw_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_push;
   cls_type    q_push_cls;
   logic       q_pop;
   logic       q_full;
   q_head_type q_head;

   // Terms used by the checks at the end of the module.
   logic       rsp_is_repeat;
   logic       rsp_blank;
   logic       rsp_is_good;
   logic       out_blocked;

   // Configuration registers. Writes to indexes past the list are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_MIN:   cfg_in.zero_min      = csr_data;
            CSR_ONE_MIN:    cfg_in.one_min       = csr_data;
            CSR_REPEAT_MIN: cfg_in.repeat_min    = csr_data;
            CSR_LEAD_MIN:   cfg_in.lead_min      = csr_data;
            CSR_TIMEOUT:    cfg_in.timeout       = csr_data;
            CSR_ADDR_CHECK: cfg_in.addr_check    = csr_data[0];
            CSR_EXPECTED:   cfg_in.expected_addr = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_min      <= RESET_ZERO_MIN;
         cfg_ff.one_min       <= RESET_ONE_MIN;
         cfg_ff.repeat_min    <= RESET_REPEAT_MIN;
         cfg_ff.lead_min      <= RESET_LEAD_MIN;
         cfg_ff.timeout       <= RESET_TIMEOUT;
         cfg_ff.addr_check    <= 1'b0;
         cfg_ff.expected_addr <= RESET_EXPECTED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The classifier accepts a word whenever the queue has room.
   irpw_front u_front (
      .req_valid      (req_valid),
      .req_high_ticks (req_high_ticks),
      .cfg            (cfg_ff),
      .q_full         (q_full),
      .req_stall      (req_stall),
      .push           (q_push),
      .push_cls       (q_push_cls)
   );

   // The queue lets the classifier keep running while the output is stalled.
   irpw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cls (q_push_cls),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full)
   );

   // The frame engine owns all decoder state and the output register.
   irpw_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head             (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_frame_word   (rsp_frame_word),
      .rsp_address_byte (rsp_address_byte),
      .rsp_key_code     (rsp_key_code),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_repeat_count (rsp_repeat_count)
   );

   assign rsp_is_repeat = rsp_valid && (rsp_result_kind == KIND_REPEAT);
   assign rsp_blank     = (rsp_frame_word == '0) && !rsp_frame_ok;
   assign rsp_is_good   = rsp_valid && rsp_frame_ok;
   assign out_blocked   = q_full && rsp_valid && rsp_stall && !req_valid;

   // The engine must never pop an empty queue.
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, q_pop, q_head.valid)
   // A repeat word carries no frame content.
   `ASSERT_IMPLIES(a_repeat_clean, clock, reset, rsp_is_repeat, rsp_blank)
   // A valid frame reports the key byte taken from its own frame word.
   `ASSERT_IMPLIES(a_key_matches, clock, reset, rsp_is_good, rsp_key_code == rsp_frame_word[15:8])
   // A full queue with a stalled output cannot drain in the next cycle.
   `ASSERT_NEXT(a_full_holds, clock, reset, out_blocked, q_head.valid)

endmodule

// ===== tb/ir_pulse_width_frame_decoder_test.sv =====
// Self-checking testbench of the pulse-width infrared remote frame decoder.
`timescale 1ns / 1ps

module ir_pulse_width_frame_decoder_test;
   import irpw_pkg::*;

   // Items that make no result can still sit in the pipe after the last
   // result arrives, so the block is given this many quiet cycles before
   // its registers are touched or the run ends.
   localparam int SETTLE_CYCLES = 8;

   // The watchdog fires after this many cycles with no handshake on any port.
   // Gaps in a correct run come from random idling and stalls, so this is
   // very generous.
   localparam int QUIET_LIMIT = 2000;

   localparam int PHASE_COUNT = 6;

   typedef struct packed {
      logic                 result_kind;
      logic [31:0]          frame_word;
      logic [BYTE_BITS-1:0] address_byte;
      logic [BYTE_BITS-1:0] key_code;
      logic                 frame_ok;
      logic [BYTE_BITS-1:0] repeat_count;
   } decoded_word_type;

   // A directed row is either one duration word or a whole frame, which
   // expands into a lead pulse followed by thirty-two data pulses.
   typedef enum logic {ROW_PULSE, ROW_FRAME} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [31:0]      value;
      logic             typed;
      logic             has_result;
      decoded_word_type word;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid;
   logic                     req_stall;
   logic [DURATION_BITS-1:0] req_high_ticks;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_result_kind;
   logic [FRAME_BITS-1:0]    rsp_frame_word;
   logic [BYTE_BITS-1:0]     rsp_address_byte;
   logic [BYTE_BITS-1:0]     rsp_key_code;
   logic                     rsp_frame_ok;
   logic [BYTE_BITS-1:0]     rsp_repeat_count;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CFG_BITS-1:0]      csr_data;

   ir_pulse_width_frame_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_high_ticks   (req_high_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_frame_word   (rsp_frame_word),
      .rsp_address_byte (rsp_address_byte),
      .rsp_key_code     (rsp_key_code),
      .rsp_frame_ok     (rsp_frame_ok),
      .rsp_repeat_count (rsp_repeat_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Settings and decoder state as the predictor sees them. The settings
   // copy changes only once a full set of register writes has gone through.
   cfg_type              thresholds;
   logic [31:0]          frame_shift;
   logic [5:0]           bits_in;
   logic                 receiving;
   logic [BYTE_BITS-1:0] repeat_tally;

   decoded_word_type pending_words[$];
   stim_row_type     directed_rows[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int pulses_sent   = 0;
   int word_errors   = 0;
   int quiet_cycles  = 0;

   // Sorts one duration by the fixed priority order. With misordered
   // thresholds the higher-priority class simply wins.
   function automatic cls_type classify(input logic [DURATION_BITS-1:0] d);
      if (d >= thresholds.timeout)    return CLS_TIMEOUT;
      if (d >= thresholds.lead_min)   return CLS_LEAD;
      if (d >= thresholds.repeat_min) return CLS_REPEAT;
      if (d >= thresholds.one_min)    return CLS_ONE;
      if (d >= thresholds.zero_min)   return CLS_ZERO;
      return CLS_NOISE;
   endfunction

   // Advances the decoder state by one duration and returns 1 when the
   // duration produces a result word, which is then left in w.
   function automatic bit decode_pulse(input logic [DURATION_BITS-1:0] d,
                                       output decoded_word_type w);
      cls_type c;
      logic    ok;
      w = '0;
      c = classify(d);
      case (c)
         CLS_TIMEOUT: begin
            receiving = 1'b0;
            bits_in   = '0;
            return 1'b0;
         end
         CLS_LEAD: begin
            frame_shift  = '0;
            bits_in      = '0;
            repeat_tally = '0;
            receiving    = 1'b1;
            return 1'b0;
         end
         CLS_REPEAT: begin
            // A repeat code never touches the frame being assembled.
            if (repeat_tally != REPEAT_SATURATE) repeat_tally++;
            w.result_kind  = KIND_REPEAT;
            w.repeat_count = repeat_tally;
            return 1'b1;
         end
         CLS_ONE, CLS_ZERO: begin
            if (!receiving) return 1'b0;
            frame_shift = {frame_shift[30:0], c == CLS_ONE};
            bits_in++;
            if (bits_in < 6'(FRAME_BITS)) return 1'b0;
            ok = (frame_shift[31:24] == ~frame_shift[23:16]) &&
                 (frame_shift[15:8] == ~frame_shift[7:0]);
            if (thresholds.addr_check && frame_shift[31:24] != thresholds.expected_addr)
               ok = 1'b0;
            receiving        = 1'b0;
            bits_in          = '0;
            w.result_kind    = KIND_FRAME;
            w.frame_word     = frame_shift;
            w.address_byte   = frame_shift[31:24];
            w.key_code       = ok ? frame_shift[15:8] : 8'd0;
            w.frame_ok       = ok;
            w.repeat_count   = repeat_tally;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Picks a duration of the wanted class under the current thresholds,
   // leaning toward both edges of its range. A class that the thresholds
   // leave empty falls back to any duration at all.
   function automatic logic [DURATION_BITS-1:0] pick_ticks(input cls_type c);
      int th[5];
      int rank;
      int lo;
      int hi;
      th   = '{int'(thresholds.timeout), int'(thresholds.lead_min),
               int'(thresholds.repeat_min), int'(thresholds.one_min),
               int'(thresholds.zero_min)};
      rank = int'(CLS_TIMEOUT) - int'(c);
      hi   = 256;
      for (int k = 0; k < rank; k++) if (th[k] < hi) hi = th[k];
      lo = (rank < 5) ? th[rank] : 0;
      if (lo >= hi) return DURATION_BITS'($urandom_range(255));
      case ($urandom_range(3))
         0:       return DURATION_BITS'(lo);
         1:       return DURATION_BITS'(hi - 1);
         default: return DURATION_BITS'($urandom_range(hi - 1, lo));
      endcase
   endfunction

   // Settings of each random phase: shipped defaults with the address check,
   // the tightest possible ladder, everything at the top, everything at the
   // bottom with a timeout of one, a ladder with one and zero swapped, and
   // then a random ordered ladder.
   function automatic cfg_type phase_settings(input int phase_no);
      cfg_type s;
      int      z;
      int      o;
      int      r;
      int      l;
      case (phase_no)
         0: s = '{zero_min: RESET_ZERO_MIN, one_min: RESET_ONE_MIN,
                  repeat_min: RESET_REPEAT_MIN, lead_min: RESET_LEAD_MIN,
                  timeout: RESET_TIMEOUT, addr_check: 1'b1,
                  expected_addr: 8'($urandom_range(255))};
         1: s = '{zero_min: 8'd0, one_min: 8'd1, repeat_min: 8'd2, lead_min: 8'd3,
                  timeout: 8'd255, addr_check: 1'b1, expected_addr: 8'd255};
         2: s = '{zero_min: 8'd255, one_min: 8'd255, repeat_min: 8'd255,
                  lead_min: 8'd255, timeout: 8'd255, addr_check: 1'b0,
                  expected_addr: 8'd0};
         3: s = '{zero_min: 8'd0, one_min: 8'd0, repeat_min: 8'd0, lead_min: 8'd0,
                  timeout: 8'd1, addr_check: 1'b0, expected_addr: 8'd0};
         4: s = '{zero_min: 8'd80, one_min: 8'd40, repeat_min: 8'd120,
                  lead_min: 8'd180, timeout: 8'd240, addr_check: 1'b1,
                  expected_addr: 8'd0};
         default: begin
            z = $urandom_range(40, 1);
            o = z + $urandom_range(40, 1);
            r = o + $urandom_range(40, 1);
            l = r + $urandom_range(40, 1);
            s = '{zero_min: 8'(z), one_min: 8'(o), repeat_min: 8'(r), lead_min: 8'(l),
                  timeout: 8'(l + $urandom_range(255 - l, 1)),
                  addr_check: 1'($urandom_range(1)),
                  expected_addr: 8'($urandom_range(255))};
         end
      endcase
      return s;
   endfunction

   // Drives one duration word and waits for it to be taken. The predictor
   // always runs so that its state keeps in step; on a typed row the
   // expectation written in the table replaces the predicted one.
   task automatic send_pulse(input logic [DURATION_BITS-1:0] d,
                             input logic typed = 1'b0,
                             input logic given_has = 1'b0,
                             input decoded_word_type given = '0);
      decoded_word_type w;
      bit               has;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_high_ticks <= d;
      do @(posedge clock); while (req_stall);
      has = decode_pulse(d, w);
      if (typed) begin
         has = given_has;
         w   = given;
      end
      if (has) pending_words.push_back(w);
      pulses_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every expected word has come out, and then
   // lets the pipe empty of words that make no result.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Writes all seven registers back to back. The address check register
   // only keeps its low bit, so the upper bits carry random junk.
   task automatic apply_settings(input cfg_type s);
      write_reg(CSR_ZERO_MIN, s.zero_min);
      write_reg(CSR_ONE_MIN, s.one_min);
      write_reg(CSR_REPEAT_MIN, s.repeat_min);
      write_reg(CSR_LEAD_MIN, s.lead_min);
      write_reg(CSR_TIMEOUT, s.timeout);
      write_reg(CSR_ADDR_CHECK, {7'($urandom_range(127)), s.addr_check});
      write_reg(CSR_EXPECTED, s.expected_addr);
      csr_valid  <= 1'b0;
      thresholds  = s;
   endtask

   // Sends a lead pulse and the bits of a frame, first bit first. Stray noise
   // and repeat codes are sprinkled between the bits. When abort_at is below
   // thirty-two the frame is cut off there by a timeout or a fresh lead.
   task automatic send_frame(input logic [31:0] frame, input int abort_at);
      send_pulse(pick_ticks(CLS_LEAD));
      for (int i = 0; i < FRAME_BITS; i++) begin
         if (i == abort_at) begin
            send_pulse(pick_ticks($urandom_range(1) ? CLS_TIMEOUT : CLS_LEAD));
            break;
         end
         if ($urandom_range(99) < 5) send_pulse(pick_ticks(CLS_NOISE));
         else if ($urandom_range(99) < 3) send_pulse(pick_ticks(CLS_REPEAT));
         send_pulse(pick_ticks(frame[31 - i] ? CLS_ONE : CLS_ZERO));
      end
   endtask

   // One random sequence. Most are well-formed frames, since only those pass
   // the complement checks; the rest are arbitrary frames, cut-off
   // frames and loose durations of any value.
   task automatic send_sequence();
      logic [7:0] addr;
      logic [7:0] key;
      int         pick;
      pick = $urandom_range(99);
      addr = $urandom_range(1) ? thresholds.expected_addr : 8'($urandom_range(255));
      key  = 8'($urandom_range(255));
      if (pick < 60) begin
         send_frame({addr, ~addr, key, ~key}, FRAME_BITS);
         repeat ($urandom_range(3)) send_pulse(pick_ticks(CLS_REPEAT));
      end else if (pick < 75) begin
         send_frame($urandom, FRAME_BITS);
      end else if (pick < 88) begin
         send_frame($urandom, $urandom_range(FRAME_BITS - 1));
      end else begin
         repeat ($urandom_range(4, 1)) send_pulse(DURATION_BITS'($urandom_range(255)));
      end
   endtask

   // The receiver stalls at random at the rate the current phase sets.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Every result word taken by the receiver is checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      decoded_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected: kind %0b frame %h",
                   rsp_result_kind, rsp_frame_word);
            word_errors++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_result_kind !== want.result_kind) begin
               $error("rsp_result_kind: expected %0b, got %0b",
                      want.result_kind, rsp_result_kind);
               word_errors++;
            end
            if (rsp_frame_word !== want.frame_word) begin
               $error("rsp_frame_word: expected %h, got %h", want.frame_word, rsp_frame_word);
               word_errors++;
            end
            if (rsp_address_byte !== want.address_byte) begin
               $error("rsp_address_byte: expected %h, got %h",
                      want.address_byte, rsp_address_byte);
               word_errors++;
            end
            if (rsp_key_code !== want.key_code) begin
               $error("rsp_key_code: expected %h, got %h", want.key_code, rsp_key_code);
               word_errors++;
            end
            if (rsp_frame_ok !== want.frame_ok) begin
               $error("rsp_frame_ok: expected %0b, got %0b", want.frame_ok, rsp_frame_ok);
               word_errors++;
            end
            if (rsp_repeat_count !== want.repeat_count) begin
               $error("rsp_repeat_count: expected %0d, got %0d",
                      want.repeat_count, rsp_repeat_count);
               word_errors++;
            end
         end
      end
   end

   // The watchdog counts cycles in which no port moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int      phase_start;
      int      budget;
      bit      paused;
      logic    [DURATION_BITS-1:0] dur;
      cfg_type s;

      req_valid      = 1'b0;
      req_high_ticks = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;

      // The predictor starts from the reset values of the block.
      thresholds   = '{zero_min: RESET_ZERO_MIN, one_min: RESET_ONE_MIN,
                       repeat_min: RESET_REPEAT_MIN, lead_min: RESET_LEAD_MIN,
                       timeout: RESET_TIMEOUT, addr_check: 1'b0,
                       expected_addr: RESET_EXPECTED};
      frame_shift  = '0;
      bits_in      = '0;
      receiving    = 1'b0;
      repeat_tally = '0;

      // The directed part runs on the reset thresholds: zero bits from 10,
      // one bits from 50, repeats from 100, leads from 200, timeout at 250.
      // Noise at the very bottom, just under a zero bit, and data bits with
      // no frame open must all be dropped.
      directed_rows.push_back('{ROW_PULSE, 32'd0,   1'b1, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd9,   1'b1, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd10,  1'b1, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd99,  1'b1, 1'b0, '0});
      // A timeout at the top of the range and at its exact threshold.
      directed_rows.push_back('{ROW_PULSE, 32'd255, 1'b1, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd250, 1'b1, 1'b0, '0});
      // Repeats count up from reset, and a lead pulse clears the count.
      directed_rows.push_back('{ROW_PULSE, 32'd100, 1'b1, 1'b1,
                                '{KIND_REPEAT, 32'd0, 8'd0, 8'd0, 1'b0, 8'd1}});
      directed_rows.push_back('{ROW_PULSE, 32'd199, 1'b1, 1'b1,
                                '{KIND_REPEAT, 32'd0, 8'd0, 8'd0, 1'b0, 8'd2}});
      directed_rows.push_back('{ROW_PULSE, 32'd249, 1'b1, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd100, 1'b1, 1'b1,
                                '{KIND_REPEAT, 32'd0, 8'd0, 8'd0, 1'b0, 8'd1}});
      // Frames at the extremes: one that passes both complement checks and
      // one that fails them, so the key reads back as zero.
      directed_rows.push_back('{ROW_FRAME, 32'h00FF00FF, 1'b1, 1'b1,
                                '{KIND_FRAME, 32'h00FF00FF, 8'h00, 8'h00, 1'b1, 8'd0}});
      directed_rows.push_back('{ROW_FRAME, 32'hFFFFFFFF, 1'b1, 1'b1,
                                '{KIND_FRAME, 32'hFFFFFFFF, 8'hFF, 8'h00, 1'b0, 8'd0}});
      // A timeout in the middle of a frame drops back to idle, so the bit
      // after it is ignored.
      directed_rows.push_back('{ROW_PULSE, 32'd200, 1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd50,  1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd250, 1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd50,  1'b0, 1'b0, '0});
      // A lead pulse in the middle of a frame starts it over.
      directed_rows.push_back('{ROW_PULSE, 32'd200, 1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd10,  1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_FRAME, 32'h12ED34CB, 1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd150, 1'b0, 1'b0, '0});
      directed_rows.push_back('{ROW_PULSE, 32'd150, 1'b0, 1'b0, '0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Frame rows use the edges of the zero and one ranges, alternating
      // from bit to bit.
      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_PULSE) begin
            send_pulse(directed_rows[n].value[7:0], directed_rows[n].typed,
                       directed_rows[n].has_result, directed_rows[n].word);
         end else begin
            send_pulse(8'd200, directed_rows[n].typed);
            for (int i = 0; i < FRAME_BITS; i++) begin
               if (directed_rows[n].value[31 - i])
                  dur = (i % 2) ? 8'd99 : 8'd50;
               else
                  dur = (i % 2) ? 8'd49 : 8'd10;
               send_pulse(dur, directed_rows[n].typed,
                          directed_rows[n].has_result && (i == FRAME_BITS - 1),
                          directed_rows[n].word);
            end
         end
      end
      drain();

      // Random phases. The handshake pressure cycles through no idling, a
      // mostly idle sender, a mostly stalling receiver and a bit of both.
      // A phase that runs past half its budget waits for every result
      // before going on, and every phase ends by waiting for all of them.
      for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
         s = phase_settings(phase_no);
         apply_settings(s);
         case (phase_no % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 72; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         // Phase zero is spent on a long run of repeat codes. The extreme
         // ladders of phases two and three leave little to decode, so they
         // get a short run.
         if (phase_no == 0)
            budget = 0;
         else
            budget = (phase_no == 2 || phase_no == 3) ? 8 : 20;
         phase_start = pulses_sent;
         paused      = 1'b0;
         if (phase_no == 0) begin
            // Enough repeat codes in a row to pin the counter at its ceiling.
            repeat (256) send_pulse(pick_ticks(CLS_REPEAT));
            phase_start = pulses_sent;
         end
         while (pulses_sent - phase_start < budget) begin
            if (!paused && pulses_sent - phase_start >= budget / 2) begin
               drain();
               paused = 1'b1;
            end
            send_sequence();
         end
         drain();
      end

      if (word_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
